FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, screen geometry and helpers of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  // wide enough for any linear position and for CELLS itself
  localparam int WIDE_W = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [APB_ADDR_W-1:0] REG_TEXT_ATTR_ADDR = 2'b00;
  localparam logic [7:0]            ATTR_RESET         = 8'h07;
  localparam logic [7:0]            CHAR_NUL           = 8'h00;
  localparam logic [7:0]            CHAR_NEWLINE       = 8'h0A;
  localparam logic                  FUNC_PUT           = 1'b0;
  localparam logic                  FUNC_READ          = 1'b1;

  typedef struct packed {
    logic             func;
    logic [7:0]       char_code;
    logic             end_of_message;
    logic [IDX_W-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic             cursor_valid;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SCROLL = 4'b1000
  } state_t;

  // the screen is a ring of rows: logical cell plus top-row base, modulo CELLS
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// character and attribute store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic               clk,
  input  tcw_pkg::ram_req_t  req,
  output tcw_pkg::cell_t     rdata
);
  import tcw_pkg::*;

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/core/tcw_apb_regs.sv
// ----------------------------------------------------------------------------
// tcw_apb_regs
// apb slave holding the text attribute register
// ----------------------------------------------------------------------------
module tcw_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [7:0]                     text_attribute
);
  import tcw_pkg::*;

  assign pready = 1'b1;

  // single register: every write lands in it
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite) begin
      text_attribute <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == REG_TEXT_ATTR_ADDR) ? APB_DATA_W'(text_attribute) : '0;

endmodule

FILE: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// cursor, scroll base, screen clearing and read sequencing, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_word_t out_data,
  input  logic [7:0]         text_attribute,
  output tcw_pkg::ram_req_t  ram_req,
  input  tcw_pkg::cell_t     ram_rdata
);
  import tcw_pkg::*;

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  scr_cnt;
  logic [COL_W-1:0]  cur_col, col_next;
  logic [ROW_W-1:0]  cur_row, row_next;
  logic [ADDR_W-1:0] row_start, row_start_next;
  logic [ADDR_W-1:0] base, base_next;
  logic [ADDR_W:0]   base_sum;
  logic              skip, skip_next;
  logic              rd_hit;

  logic              in_fire, is_put, do_print, do_nl, adv, do_scroll;
  logic              at_last_col, at_last_row;
  logic [ADDR_W-1:0] cur_lin;
  logic [WIDE_W-1:0] pos_now, pos_next, idx_wide;
  logic              idx_hit;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign is_put   = (in_data.func == FUNC_PUT);

  assign do_print = is_put && !skip && (in_data.char_code != CHAR_NUL) &&
                    (in_data.char_code != CHAR_NEWLINE);
  assign do_nl    = is_put && !skip && (in_data.char_code == CHAR_NEWLINE);

  assign at_last_col = (cur_col == COL_W'(COLUMNS - 1));
  assign at_last_row = (cur_row == ROW_W'(ROWS - 1));
  assign adv         = do_nl || (do_print && at_last_col);
  assign do_scroll   = adv && at_last_row;

  assign cur_lin = row_start + ADDR_W'(cur_col);

  // cursor, scroll base and skip flag after a put word
  always_comb begin
    col_next       = cur_col;
    row_next       = cur_row;
    row_start_next = row_start;
    base_next      = base;
    base_sum       = {1'b0, base} + (ADDR_W+1)'(COLUMNS);
    if (adv) begin
      col_next = '0;
    end else if (do_print) begin
      col_next = cur_col + 1'b1;
    end
    if (adv && !at_last_row) begin
      row_next       = cur_row + 1'b1;
      row_start_next = row_start + ADDR_W'(COLUMNS);
    end
    // scrolling moves the top of the ring down one row
    if (do_scroll) begin
      base_next = (base_sum >= (ADDR_W+1)'(CELLS)) ? '0 : base_sum[ADDR_W-1:0];
    end
    if (in_data.end_of_message) begin
      skip_next = 1'b0;
    end else if (is_put && !skip && (in_data.char_code == CHAR_NUL)) begin
      skip_next = 1'b1;
    end else begin
      skip_next = skip;
    end
  end

  assign pos_now  = WIDE_W'(row_start) + WIDE_W'(cur_col);
  assign pos_next = WIDE_W'(row_start_next) + WIDE_W'(col_next);
  assign idx_wide = WIDE_W'(in_data.cell_index);
  assign idx_hit  = (idx_wide < WIDE_W'(CELLS));

  always_comb begin
    ram_req       = '0;
    ram_req.raddr = phys_addr(idx_wide[ADDR_W-1:0], base);
    case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
      end
      ST_IDLE: begin
        if (in_fire && do_print) begin
          ram_req.we         = 1'b1;
          ram_req.waddr      = phys_addr(cur_lin, base);
          ram_req.wdata.ch   = in_data.char_code;
          ram_req.wdata.attr = text_attribute;
        end
        ram_req.re = in_fire && !is_put && idx_hit;
      end
      ST_SCROLL: begin
        // base already moved, so row_start plus base is the freed row
        ram_req.we    = 1'b1;
        ram_req.waddr = phys_addr(row_start + ADDR_W'(scr_cnt), base);
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_put) begin
            state_next = ST_READ;
          end else if (do_scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        if (scr_cnt == COL_W'(COLUMNS - 1)) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      scr_cnt   <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      row_start <= '0;
      base      <= '0;
      skip      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_SCROLL) begin
        scr_cnt <= scr_cnt + 1'b1;
      end else begin
        scr_cnt <= '0;
      end
      if (in_fire && is_put) begin
        cur_col   <= col_next;
        cur_row   <= row_next;
        row_start <= row_start_next;
        base      <= base_next;
        skip      <= skip_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_put) begin
      rd_hit <= idx_hit;
    end
  end

  // output register: put words load at accept, read words in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_fire && is_put) || (state == ST_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_put) begin
      out_data.cursor_pos   <= pos_next[POS_W-1:0];
      out_data.cursor_valid <= in_data.end_of_message;
      out_data.cell_char    <= '0;
      out_data.cell_attr    <= '0;
    end else if (state == ST_READ) begin
      out_data.cursor_pos   <= pos_now[POS_W-1:0];
      out_data.cursor_valid <= 1'b0;
      out_data.cell_char    <= rd_hit ? ram_rdata.ch : '0;
      out_data.cell_attr    <= rd_hit ? ram_rdata.attr : '0;
    end
  end

  `ASSERT_ALWAYS(a_cursor_range, clk, rst, (int'(cur_col) < COLUMNS) && (int'(cur_row) < ROWS), "cursor outside the screen")
  `ASSERT_ALWAYS(a_row_start, clk, rst, int'(row_start) == int'(cur_row) * COLUMNS, "row start out of step with cursor row")
  `ASSERT_ALWAYS(a_base_range, clk, rst, int'(base) < CELLS, "scroll base beyond the screen")
  `ASSERT_IMPLY(a_read_slot, clk, rst, state == ST_READ, !out_valid, "read data lands on a full output register")
  `ASSERT_NEXT(a_scroll_entry, clk, rst, in_fire && do_scroll, (state == ST_SCROLL) && (scr_cnt == '0) && (int'(cur_row) == ROWS - 1), "scroll did not start on the bottom row")

endmodule

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: teletype writer on a ring-buffered screen memory
// put word: result registered at accept; read word: ram read port, then output in ST_READ
// scroll: clears the new bottom row (COLUMNS cells), one cell per cycle
// sync reset, then all CELLS (2000) cells of the screen ram are cleared before any input
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tcw_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tcw_pkg::out_word_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tcw_pkg::*;

  logic [7:0] text_attribute;
  ram_req_t   ram_req;
  cell_t      ram_rdata;

  tcw_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_attribute (text_attribute)
  );

  tcw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .text_attribute (text_attribute),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  tcw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule
